// ----- rtl/khte_pkg.sv -----
// -----------------------------------------------------------------------------
// khte_pkg: shared types and constants of the key hold-time event engine
// Sizes, register indexes, item kinds, controller states and the command and
// status groups between controller and datapath.
// -----------------------------------------------------------------------------
`default_nettype none

package khte_pkg;

   localparam int KEYS          = 8;
   localparam int SLOTS_PER_KEY = 4;
   localparam int TIMER_BITS    = 16;
   localparam int MAX_RESULTS   = 32;
   localparam int ENTRIES       = KEYS * SLOTS_PER_KEY;

   localparam int KEY_W  = (KEYS > 1) ? $clog2(KEYS) : 1;
   localparam int SLOT_W = (SLOTS_PER_KEY > 1) ? $clog2(SLOTS_PER_KEY) : 1;
   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W  = $clog2(MAX_RESULTS + 1);
   localparam int CMP_W  = (TIMER_BITS > 16) ? TIMER_BITS : 16;
   localparam int SUM_W  = CMP_W + 1;

   localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

   localparam logic [1:0] CSR_MODE      = 2'd0;
   localparam logic [1:0] CSR_LOCK      = 2'd1;
   localparam logic [1:0] CSR_DEBOUNCE  = 2'd2;
   localparam logic [1:0] CSR_INCREMENT = 2'd3;

   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   localparam logic [15:0] DEBOUNCE_RESET  = 16'd20;
   localparam logic [15:0] INCREMENT_RESET = 16'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_KEY,
      ST_SLOT,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic start;
      logic write;
      logic key_update;
      logic key_next;
      logic slot_commit;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic key_active;
      logic fire;
      logic last_key;
      logic last_slot;
      logic pend_valid;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// ----- rtl/key_hold_time_event_engine.sv -----
// A write transaction is done without leaving the idle state; a tick visits every key and walks the
// slots of each unlocked key with a valid slot, then flushes the final event.
// Throughput: one tick at a time; the walk over a key's slots takes one entry per cycle while not stalled.
// A full output register stalls the walk on a firing slot until the event moves out.
// Synchronous reset clears key timers, entry valid bits and registers to defaults.
// -----------------------------------------------------------------------------
// key_hold_time_event_engine: top level
// Per-key debounce and hold-time event detector with a programmable response
// table of press and release events.
// -----------------------------------------------------------------------------
`default_nettype none

module key_hold_time_event_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_key_states,
   input  wire logic [2:0]  req_entry_key,
   input  wire logic [1:0]  req_entry_slot,
   input  wire logic [15:0] req_entry_time,
   input  wire logic        req_entry_valid,
   input  wire logic        req_entry_on_press,
   input  wire logic        req_entry_on_release,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_key_index,
   output logic [1:0]       rsp_slot_index,
   output logic             rsp_pressed,
   output logic             rsp_last
);

   khte_pkg::cmd_type    cmd;
   khte_pkg::status_type status;

   khte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   khte_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_key_states       (req_key_states),
      .req_entry_key        (req_entry_key),
      .req_entry_slot       (req_entry_slot),
      .req_entry_time       (req_entry_time),
      .req_entry_valid      (req_entry_valid),
      .req_entry_on_press   (req_entry_on_press),
      .req_entry_on_release (req_entry_on_release),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_key_index        (rsp_key_index),
      .rsp_slot_index       (rsp_slot_index),
      .rsp_pressed          (rsp_pressed),
      .rsp_last             (rsp_last)
   );

endmodule

`default_nettype wire

// ----- rtl/khte_ctrl.sv -----
// -----------------------------------------------------------------------------
// khte_ctrl: sequencer of the key hold-time event engine
// Walks keys and their response slots for a tick, holds on a full output
// and closes the tick by flushing the pending event.
// -----------------------------------------------------------------------------
`default_nettype none

module khte_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_kind,
   output logic                      req_stall,
   input  wire khte_pkg::status_type status,
   output khte_pkg::cmd_type         cmd
);

   khte_pkg::state_type state_ff, state_in;
   logic blocked;

   // a firing slot must wait when the pending event cannot move out
   assign blocked = status.fire && status.pend_valid && !status.out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= khte_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         khte_pkg::ST_IDLE: begin
            if (req_valid && req_kind == khte_pkg::KIND_TICK) state_in = khte_pkg::ST_KEY;
         end
         khte_pkg::ST_KEY: begin
            if (status.key_active) state_in = khte_pkg::ST_SLOT;
            else if (status.last_key) state_in = khte_pkg::ST_FLUSH;
         end
         khte_pkg::ST_SLOT: begin
            if (!blocked && status.last_slot) begin
               state_in = status.last_key ? khte_pkg::ST_FLUSH : khte_pkg::ST_KEY;
            end
         end
         khte_pkg::ST_FLUSH: begin
            if (!status.pend_valid || status.out_free) state_in = khte_pkg::ST_IDLE;
         end
         default: state_in = khte_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != khte_pkg::ST_IDLE);
      unique case (state_ff)
         khte_pkg::ST_IDLE: begin
            cmd.start = req_valid && req_kind == khte_pkg::KIND_TICK;
            cmd.write = req_valid && req_kind == khte_pkg::KIND_WRITE;
         end
         khte_pkg::ST_KEY: begin
            cmd.key_update = 1'b1;
            cmd.key_next   = !status.key_active && !status.last_key;
         end
         khte_pkg::ST_SLOT: begin
            cmd.slot_commit = !blocked;
            cmd.key_next    = !blocked && status.last_slot && !status.last_key;
         end
         khte_pkg::ST_FLUSH: begin
            cmd.flush = status.pend_valid && status.out_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/khte_datapath.sv -----
// -----------------------------------------------------------------------------
// khte_datapath: key timers, response table and event registers
// Holds per-key state and timers, the response entries, the configuration
// registers, the pending event and the output register.
// -----------------------------------------------------------------------------
`default_nettype none

module khte_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire khte_pkg::cmd_type cmd,
   output khte_pkg::status_type   status,
   input  wire logic [7:0]        req_key_states,
   input  wire logic [2:0]        req_entry_key,
   input  wire logic [1:0]        req_entry_slot,
   input  wire logic [15:0]       req_entry_time,
   input  wire logic              req_entry_valid,
   input  wire logic              req_entry_on_press,
   input  wire logic              req_entry_on_release,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [15:0]       csr_wdata,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [2:0]             rsp_key_index,
   output logic [1:0]             rsp_slot_index,
   output logic                   rsp_pressed,
   output logic                   rsp_last
);

   localparam int KW = khte_pkg::KEY_W;
   localparam int SW = khte_pkg::SLOT_W;
   localparam int IW = khte_pkg::IDX_W;
   localparam int CW = khte_pkg::CNT_W;
   localparam int TW = khte_pkg::TIMER_BITS;
   localparam int MW = khte_pkg::CMP_W;
   localparam int UW = khte_pkg::SUM_W;

   // configuration
   logic [7:0]  mode_ff, lock_ff;
   logic [15:0] debounce_ff, incr_ff;

   // response table
   logic [khte_pkg::ENTRIES-1:0] valid_ff, press_ff, release_ff;
   logic [15:0]                  time_ff [khte_pkg::ENTRIES];
   logic [15:0]                  time_rd_ff;

   // per-key state
   logic          last_ff  [khte_pkg::KEYS];
   logic [TW-1:0] hold_ff  [khte_pkg::KEYS];
   logic [TW-1:0] other_ff [khte_pkg::KEYS];

   // walk state
   logic [7:0]    states_ff;
   logic [KW-1:0] key_ff, key_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   // pending event and output register
   logic       pend_valid_ff, pend_valid_in;
   logic [2:0] pend_key_ff;
   logic [1:0] pend_slot_ff;
   logic       pend_pressed_ff;
   logic       out_valid_ff, out_valid_in;
   logic [2:0] out_key_ff;
   logic [1:0] out_slot_ff;
   logic       out_pressed_ff, out_last_ff;

   logic [7:0]    key_x;
   logic          key_in_mask;
   logic          cur, mode_bit, lock_bit, any_valid;
   logic [IW-1:0] rd_idx, wr_idx, nxt_idx;
   logic          wr_ok;
   logic [TW-1:0] hold_cur, other_cur;
   logic          last_cur;
   logic [UW-1:0] sum;
   logic [TW-1:0] hold_sat;
   logic [MW-1:0] hold_x, time_x;
   logic          cond, enable, fire, push_evt, push;
   logic          out_free;

   assign key_x       = 8'(key_ff);
   assign key_in_mask = key_x < 8'd8;
   assign cur         = key_in_mask && states_ff[key_x[2:0]];
   assign mode_bit    = key_in_mask && mode_ff[key_x[2:0]];
   assign lock_bit    = key_in_mask && lock_ff[key_x[2:0]];

   assign rd_idx  = IW'(int'(key_ff) * khte_pkg::SLOTS_PER_KEY + int'(slot_ff));
   assign nxt_idx = IW'(int'(key_in) * khte_pkg::SLOTS_PER_KEY + int'(slot_in));
   assign wr_idx = IW'(int'(req_entry_key) * khte_pkg::SLOTS_PER_KEY + int'(req_entry_slot));
   assign wr_ok  = int'(req_entry_key) < khte_pkg::KEYS &&
                   int'(req_entry_slot) < khte_pkg::SLOTS_PER_KEY;

   always_comb begin
      any_valid = 1'b0;
      for (int s = 0; s < khte_pkg::SLOTS_PER_KEY; s++) begin
         any_valid = any_valid |
                     valid_ff[IW'(int'(key_ff) * khte_pkg::SLOTS_PER_KEY + s)];
      end
   end

   assign hold_cur  = hold_ff[key_ff];
   assign other_cur = other_ff[key_ff];
   assign last_cur  = last_ff[key_ff];

   // saturating advance of the hold timer
   assign sum      = UW'(hold_cur) + UW'(incr_ff);
   assign hold_sat = (sum > UW'(khte_pkg::TIMER_MAX)) ? khte_pkg::TIMER_MAX : TW'(sum);

   assign hold_x = MW'(hold_cur);
   assign time_x = MW'(time_rd_ff);
   assign cond   = mode_bit ? (time_x >= hold_x)
                            : (time_x == hold_x && MW'(other_cur) >= MW'(debounce_ff));
   assign enable = cur ? press_ff[rd_idx] : release_ff[rd_idx];
   assign fire   = valid_ff[rd_idx] && cond && enable && cnt_ff < CW'(khte_pkg::MAX_RESULTS);

   assign out_free = !out_valid_ff || !rsp_stall;
   assign push_evt = cmd.slot_commit && fire;
   assign push     = (push_evt && pend_valid_ff) || cmd.flush;

   assign status.key_active = any_valid && !lock_bit;
   assign status.fire       = fire;
   assign status.last_key   = key_ff == KW'(khte_pkg::KEYS - 1);
   assign status.last_slot  = slot_ff == SW'(khte_pkg::SLOTS_PER_KEY - 1);
   assign status.pend_valid = pend_valid_ff;
   assign status.out_free   = out_free;

   always_comb begin
      key_in = key_ff;
      if (cmd.start) key_in = '0;
      else if (cmd.key_next) key_in = key_ff + KW'(1);
   end

   always_comb begin
      slot_in = slot_ff;
      priority if (cmd.start || cmd.key_next) begin
         slot_in = '0;
      end else if (cmd.slot_commit && !status.last_slot) begin
         slot_in = slot_ff + SW'(1);
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.start) cnt_in = '0;
      else if (push_evt) cnt_in = cnt_ff + CW'(1);
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (push_evt) pend_valid_in = 1'b1;
      else if (cmd.flush) pend_valid_in = 1'b0;
   end

   assign out_valid_in = push || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= '0;
         lock_ff     <= '0;
         debounce_ff <= khte_pkg::DEBOUNCE_RESET;
         incr_ff     <= khte_pkg::INCREMENT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            khte_pkg::CSR_MODE:      mode_ff     <= csr_wdata[7:0];
            khte_pkg::CSR_LOCK:      lock_ff     <= csr_wdata[7:0];
            khte_pkg::CSR_DEBOUNCE:  debounce_ff <= csr_wdata;
            khte_pkg::CSR_INCREMENT: incr_ff     <= csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.write && wr_ok) begin
         valid_ff[wr_idx] <= req_entry_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write && wr_ok) begin
         time_ff[wr_idx]    <= req_entry_time;
         press_ff[wr_idx]   <= req_entry_on_press;
         release_ff[wr_idx] <= req_entry_on_release;
      end
      // fetch the entry time of the next walk position
      time_rd_ff <= time_ff[nxt_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < khte_pkg::KEYS; k++) begin
            last_ff[k]  <= 1'b0;
            hold_ff[k]  <= '0;
            other_ff[k] <= '0;
         end
      end else if (cmd.key_update && any_valid) begin
         if (cur == last_cur) begin
            hold_ff[key_ff] <= hold_sat;
         end else begin
            // state change: keep the old hold time, restart the timer
            other_ff[key_ff] <= hold_cur;
            last_ff[key_ff]  <= cur;
            hold_ff[key_ff]  <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff        <= '0;
         slot_ff       <= '0;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         key_ff        <= key_in;
         slot_ff       <= slot_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) states_ff <= req_key_states;
      if (push_evt) begin
         pend_key_ff     <= 3'(key_ff);
         pend_slot_ff    <= 2'(slot_ff);
         pend_pressed_ff <= cur;
      end
      if (push) begin
         out_key_ff     <= pend_key_ff;
         out_slot_ff    <= pend_slot_ff;
         out_pressed_ff <= pend_pressed_ff;
         out_last_ff    <= cmd.flush;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_key_index  = out_key_ff;
   assign rsp_slot_index = out_slot_ff;
   assign rsp_pressed    = out_pressed_ff;
   assign rsp_last       = out_last_ff;

endmodule

`default_nettype wire

// ----- rtl/khte_checker.sv -----
// -----------------------------------------------------------------------------
// khte_checker: port-level checks of the key hold-time event engine
// Watches the request and response channels after reset and around
// accepted transactions.
// -----------------------------------------------------------------------------
`default_nettype none

module khte_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        req_kind,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [2:0]  rsp_key_index,
   input wire logic [1:0]  rsp_slot_index,
   input wire logic        rsp_pressed,
   input wire logic        rsp_last
);

   // no result and a free request channel right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("engine not idle after reset");

   // a tick occupies the engine for at least the next cycle
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_kind == khte_pkg::KIND_TICK |=> req_stall)
      else $error("request channel free right after a tick");

   // a table write completes in its own cycle
   a_write_done: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_kind == khte_pkg::KIND_WRITE |=> !req_stall)
      else $error("request channel held after a table write");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_key_index) &&
         $stable(rsp_slot_index) && $stable(rsp_pressed) && $stable(rsp_last))
      else $error("stalled result changed");

endmodule

bind key_hold_time_event_engine khte_checker u_khte_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_kind       (req_kind),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_key_index  (rsp_key_index),
   .rsp_slot_index (rsp_slot_index),
   .rsp_pressed    (rsp_pressed),
   .rsp_last       (rsp_last)
);

`default_nettype wire
